[hdl/ragcd_pkg.sv]
`default_nettype none
package ragcd_pkg;
    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_FORM,
        ST_GCD_START,
        ST_GCD_DIV,
        ST_RED_N,
        ST_RED_N_WAIT,
        ST_RED_D,
        ST_RED_D_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        DIV_SRC_GCD,
        DIV_SRC_NUM,
        DIV_SRC_DEN
    } div_src_t;

    typedef struct packed {
        logic     load;
        logic     mul1;
        logic     mul2;
        logic     form;
        logic     gcd_init;
        logic     div_start;
        div_src_t div_src;
        logic     gcd_step;
        logic     take_num;
        logic     take_den;
        logic     out_load;
    } ctrl_t;

    typedef struct packed {
        logic d_zero;
        logic n_zero;
        logic y_zero;
        logic div_done;
    } stat_t;
endpackage
`default_nettype wire

[hdl/ragcd_divider.sv]
`default_nettype none
module ragcd_divider #(
    parameter int W = 34
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[W-1:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[W-1:0];
endmodule
`default_nettype wire

[hdl/ragcd_datapath.sv]
`default_nettype none
module ragcd_datapath #(
    parameter int IN_WIDTH = 16
) (
    input  wire logic               clk,
    input  wire logic [1:0]         mode,
    input  wire logic [IN_WIDTH-1:0] num_a,
    input  wire logic [IN_WIDTH-1:0] den_a,
    input  wire logic [IN_WIDTH-1:0] num_b,
    input  wire logic [IN_WIDTH-1:0] den_b,
    input  wire logic               rst_n,
    input  wire ragcd_pkg::ctrl_t   ctrl,
    output ragcd_pkg::stat_t        stat,
    output logic                    negative,
    output logic [31:0]             num_mag,
    output logic [30:0]             den_mag,
    output logic                    error
);
    import ragcd_pkg::*;

    localparam int PW = 2 * IN_WIDTH;
    localparam int SW = PW + 1;
    localparam int MW = SW;

    logic signed [IN_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [1:0]                 mode_reg;
    logic signed [PW-1:0]       p1_reg, p2_reg, p3_reg;
    logic signed [SW-1:0]       n_reg;
    logic signed [PW-1:0]       d_reg;
    logic                       neg_reg;
    logic [MW-1:0]              nm_reg, dm_reg, x_reg, y_reg, rn_reg, rd_reg;
    logic [MW-1:0]              dv_a, dv_b, dv_q, dv_r;
    logic                       div_done;
    logic signed [IN_WIDTH-1:0] m1a, m1b;
    logic signed [PW-1:0]       mprod;
    logic signed [SW-1:0]       n_c;
    logic signed [PW-1:0]       d_c;
    logic                       o_neg_reg, o_err_reg;
    logic [31:0]                o_num_reg;
    logic [30:0]                o_den_reg;

    always_comb
    begin
        m1a = an_reg;
        m1b = bd_reg;
        if (ctrl.load)
        begin
            m1a = num_a;
            m1b = den_b;
        end
        else if (ctrl.mul1)
        begin
            m1a = bn_reg;
            m1b = ad_reg;
        end
        else if (ctrl.mul2)
        begin
            m1a = ad_reg;
            m1b = bd_reg;
        end
        mprod = m1a * m1b;
    end

    always_comb
    begin
        d_c = p3_reg;
        unique case (mode_t'(mode_reg))
            MODE_ADD: n_c = SW'(p1_reg) + SW'(p2_reg);
            MODE_SUB: n_c = SW'(p1_reg) - SW'(p2_reg);
            MODE_MUL: n_c = SW'(an_reg * bn_reg);
            MODE_DIV:
            begin
                n_c = SW'(p1_reg);
                d_c = p2_reg;
            end
            default:  n_c = '0;
        endcase
    end

    always_comb
    begin
        dv_a = x_reg;
        dv_b = y_reg;
        case (ctrl.div_src)
            DIV_SRC_NUM: dv_a = nm_reg;
            DIV_SRC_DEN: dv_a = dm_reg;
            default:     dv_a = x_reg;
        endcase
        if (ctrl.div_src != DIV_SRC_GCD)
            dv_b = x_reg;
    end

    ragcd_divider #(.W(MW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.div_start),
        .dividend  (dv_a),
        .divisor   (dv_b),
        .done      (div_done),
        .quotient  (dv_q),
        .remainder (dv_r)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mode_reg <= mode;
            an_reg   <= num_a;
            ad_reg   <= den_a;
            bn_reg   <= num_b;
            bd_reg   <= den_b;
            p1_reg   <= mprod;
        end
        if (ctrl.mul1)
            p2_reg <= mprod;
        if (ctrl.mul2)
            p3_reg <= mprod;
        if (ctrl.form)
        begin
            n_reg <= n_c;
            d_reg <= d_c;
        end
        if (ctrl.gcd_init)
        begin
            neg_reg <= (n_reg < 0) != (d_reg < 0);
            nm_reg  <= n_reg[SW-1] ? MW'(-n_reg) : MW'(n_reg);
            dm_reg  <= d_reg[PW-1] ? MW'(-SW'(d_reg)) : MW'(SW'(d_reg));
            x_reg   <= n_reg[SW-1] ? MW'(-n_reg) : MW'(n_reg);
            y_reg   <= d_reg[PW-1] ? MW'(-SW'(d_reg)) : MW'(SW'(d_reg));
        end
        if (ctrl.gcd_step)
        begin
            x_reg <= y_reg;
            y_reg <= dv_r;
        end
        if (ctrl.take_num)
            rn_reg <= dv_q;
        if (ctrl.take_den)
            rd_reg <= dv_q;
        if (ctrl.out_load)
        begin
            if (d_reg == '0)
            begin
                o_err_reg <= 1'b1;
                o_neg_reg <= 1'b0;
                o_num_reg <= '0;
                o_den_reg <= '0;
            end
            else if (n_reg == '0)
            begin
                o_err_reg <= 1'b0;
                o_neg_reg <= 1'b0;
                o_num_reg <= '0;
                o_den_reg <= 31'd1;
            end
            else
            begin
                o_err_reg <= 1'b0;
                o_neg_reg <= neg_reg;
                o_num_reg <= 32'(rn_reg);
                o_den_reg <= 31'(rd_reg);
            end
        end
    end

    assign stat.d_zero   = (d_reg == '0);
    assign stat.n_zero   = (n_reg == '0);
    assign stat.y_zero   = (y_reg == '0);
    assign stat.div_done = div_done;
    assign negative = o_neg_reg;
    assign num_mag  = o_num_reg;
    assign den_mag  = o_den_reg;
    assign error    = o_err_reg;
endmodule
`default_nettype wire

[hdl/ragcd_ctrl.sv]
`default_nettype none
module ragcd_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic             out_taken,
    input  wire ragcd_pkg::stat_t stat,
    output ragcd_pkg::ctrl_t      ctrl,
    output logic                  in_ready,
    output logic                  out_valid
);
    import ragcd_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctrl         = '0;
        ctrl.div_src = DIV_SRC_GCD;
        ov_next      = ov_reg && !out_taken;
        in_ready     = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_MUL1;
                end
            ST_MUL1:
            begin
                ctrl.mul1  = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                ctrl.mul2  = 1'b1;
                state_next = ST_FORM;
            end
            ST_FORM:
            begin
                ctrl.form  = 1'b1;
                state_next = ST_GCD_START;
            end
            ST_GCD_START:
            begin
                if (stat.d_zero || stat.n_zero)
                    state_next = ST_OUT;
                else
                begin
                    ctrl.gcd_init = 1'b1;
                    state_next    = ST_GCD_DIV;
                end
            end
            ST_GCD_DIV:
            begin
                if (stat.y_zero)
                begin
                    ctrl.div_src   = DIV_SRC_NUM;
                    ctrl.div_start = 1'b1;
                    state_next     = ST_RED_N_WAIT;
                end
                else
                begin
                    ctrl.div_start = 1'b1;
                    state_next     = ST_RED_N;
                end
            end
            ST_RED_N:
                if (stat.div_done)
                begin
                    ctrl.gcd_step = 1'b1;
                    state_next    = ST_GCD_DIV;
                end
            ST_RED_N_WAIT:
                if (stat.div_done)
                begin
                    ctrl.take_num  = 1'b1;
                    ctrl.div_src   = DIV_SRC_DEN;
                    ctrl.div_start = 1'b1;
                    state_next     = ST_RED_D_WAIT;
                end
            ST_RED_D_WAIT:
                if (stat.div_done)
                begin
                    ctrl.take_den = 1'b1;
                    state_next    = ST_OUT;
                end
            ST_OUT:
                if (!ov_reg || out_taken)
                begin
                    ctrl.out_load = 1'b1;
                    ov_next       = 1'b1;
                    state_next    = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

[hdl/rational_arith_gcd_reduce.sv]
`default_nettype none
// rational add, subtract, multiply or divide of two signed fractions with
// euclid reduction. one word in gives one word out: sign flag, reduced
// magnitudes and a zero-denominator error flag (0/1 for a zero numerator).
// the euclid remainder steps and both final divisions all run on the shared
// bit-serial divider; a zero numerator or denominator skips them and goes
// straight to the output. one word at a time; the finished word waits in the
// output register while the next is taken.
module rational_arith_gcd_reduce #(
    parameter int IN_WIDTH = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // mode, num_a, den_a, num_b, den_b, zero fill
    input  wire logic [((4*IN_WIDTH+2+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // negative, num_mag, den_mag, error, zero fill
    output logic [71:0]                  m_tdata
);
    import ragcd_pkg::*;

    ctrl_t       ctrl;
    stat_t       stat;
    logic        negative, error;
    logic [31:0] num_mag;
    logic [30:0] den_mag;

    ragcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_tvalid && s_tready),
        .out_taken (m_tvalid && m_tready),
        .stat      (stat),
        .ctrl      (ctrl),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    ragcd_datapath #(.IN_WIDTH(IN_WIDTH)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (s_tdata[1:0]),
        .num_a    (s_tdata[2+IN_WIDTH-1:2]),
        .den_a    (s_tdata[2+2*IN_WIDTH-1:2+IN_WIDTH]),
        .num_b    (s_tdata[2+3*IN_WIDTH-1:2+2*IN_WIDTH]),
        .den_b    (s_tdata[2+4*IN_WIDTH-1:2+3*IN_WIDTH]),
        .ctrl     (ctrl),
        .stat     (stat),
        .negative (negative),
        .num_mag  (num_mag),
        .den_mag  (den_mag),
        .error    (error)
    );

    assign m_tdata = {7'd0, error, den_mag, num_mag, negative};
endmodule
`default_nettype wire
